// File: hw/rtl/skt_pkg.sv
package skt_pkg;

	// Operation codes carried in the mode field of a request item.
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	// Read address sources for the entry memories.
	localparam logic [1:0] ADDR_I       = 2'd0;
	localparam logic [1:0] ADDR_BELOW_J = 2'd1;
	localparam logic [1:0] ADDR_ABOVE_J = 2'd2;

	// Register file of the configuration port.
	localparam int         APB_ADDR_BITS  = 3;
	localparam logic       REG_KEY_SIGNED = 1'b0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] value;
	} skt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  position;
		logic [31:0] found_value;
		logic [4:0]  entry_count;
	} skt_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_op;
		logic       clr_count;
		logic       i_clr;
		logic       i_inc;
		logic       rd_en;
		logic [1:0] rd_addr_sel;
		logic       hit_clr;
		logic       hit_cap;
		logic       j_load_n;
		logic       j_load_i;
		logic       j_dec;
		logic       j_inc;
		logic       wr_en;
		logic       wr_new;
		logic       n_inc;
		logic       n_dec;
		logic       stage_en;
		logic [1:0] stage_status;
		logic       stage_pos;
		logic       stage_val;
		logic       res_load;
	} skt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic i_at_n;
		logic less;
		logic hit;
		logic j_eq_i;
		logic j_last;
		logic out_busy;
	} skt_stat_t;

endpackage

// File: hw/rtl/skt_ctrl.sv
module skt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          req_mode,
	input  skt_pkg::skt_stat_t  stat,
	output skt_pkg::skt_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CMP  = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_UP   = 4'd4;
	localparam logic [3:0] S_UPW  = 4'd5;
	localparam logic [3:0] S_DN   = 4'd6;
	localparam logic [3:0] S_DNW  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic [1:0] mode_q;

	assign req_ready = (state_q == S_IDLE);

	// State register and the operation held for the item in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= skt_pkg::MODE_INSERT;
		end else begin
			state_q <= state_nxt;
			if (req_valid && req_ready) begin
				mode_q <= req_mode;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_op = 1'b1;
					if (req_mode == skt_pkg::MODE_CLEAR) begin
						cmd.clr_count    = 1'b1;
						cmd.stage_en     = 1'b1;
						cmd.stage_status = skt_pkg::ST_OK;
						state_nxt        = S_FIN;
					end else if (req_mode == skt_pkg::MODE_INSERT && stat.full) begin
						cmd.stage_en     = 1'b1;
						cmd.stage_status = skt_pkg::ST_FULL;
						state_nxt        = S_FIN;
					end else begin
						cmd.i_clr = 1'b1;
						state_nxt = S_RD;
					end
				end
			end
			// Walk the entries in order until one is not below the key or all have been read.
			S_RD: begin
				if (stat.i_at_n) begin
					cmd.hit_clr = 1'b1;
					state_nxt   = S_DEC;
				end else begin
					cmd.rd_en       = 1'b1;
					cmd.rd_addr_sel = skt_pkg::ADDR_I;
					state_nxt       = S_CMP;
				end
			end
			S_CMP: begin
				if (stat.less) begin
					cmd.i_inc = 1'b1;
					state_nxt = S_RD;
				end else begin
					cmd.hit_cap = 1'b1;
					state_nxt   = S_DEC;
				end
			end
			// The search is over; pick the outcome for the operation.
			S_DEC: begin
				cmd.stage_en = 1'b1;
				state_nxt    = S_FIN;
				case (mode_q)
					skt_pkg::MODE_INSERT: begin
						if (stat.hit) begin
							cmd.stage_status = skt_pkg::ST_DUP;
							cmd.stage_pos    = 1'b1;
						end else begin
							cmd.stage_en = 1'b0;
							cmd.j_load_n = 1'b1;
							state_nxt    = S_UP;
						end
					end
					skt_pkg::MODE_LOOKUP, skt_pkg::MODE_DELETE: begin
						if (stat.hit) begin
							cmd.stage_status = skt_pkg::ST_OK;
							cmd.stage_pos    = 1'b1;
							cmd.stage_val    = 1'b1;
							if (mode_q == skt_pkg::MODE_DELETE) begin
								cmd.j_load_i = 1'b1;
								state_nxt    = S_DN;
							end
						end else begin
							cmd.stage_status = skt_pkg::ST_MISS;
						end
					end
					default: begin
						cmd.stage_status = skt_pkg::ST_OK;
					end
				endcase
			end
			// Move larger entries up one place, then write the new one.
			S_UP: begin
				if (stat.j_eq_i) begin
					cmd.wr_en        = 1'b1;
					cmd.wr_new       = 1'b1;
					cmd.n_inc        = 1'b1;
					cmd.stage_en     = 1'b1;
					cmd.stage_status = skt_pkg::ST_OK;
					cmd.stage_pos    = 1'b1;
					state_nxt        = S_FIN;
				end else begin
					cmd.rd_en       = 1'b1;
					cmd.rd_addr_sel = skt_pkg::ADDR_BELOW_J;
					state_nxt       = S_UPW;
				end
			end
			S_UPW: begin
				cmd.wr_en = 1'b1;
				cmd.j_dec = 1'b1;
				state_nxt = S_UP;
			end
			// Move larger entries down one place over the removed one.
			S_DN: begin
				if (stat.j_last) begin
					cmd.n_dec = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.rd_en       = 1'b1;
					cmd.rd_addr_sel = skt_pkg::ADDR_ABOVE_J;
					state_nxt       = S_DNW;
				end
			end
			S_DNW: begin
				cmd.wr_en = 1'b1;
				cmd.j_inc = 1'b1;
				state_nxt = S_DN;
			end
			// Hand the result to the output register once it is free.
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/skt_datapath.sv
module skt_datapath #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::skt_req_t   req,
	input  logic                key_signed,
	input  skt_pkg::skt_cmd_t   cmd,
	output skt_pkg::skt_stat_t  stat,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output skt_pkg::skt_rsp_t   rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [KEY_BITS-1:0] KEY_TOP = KEY_BITS'(64'd1 << (KEY_BITS - 1));
	localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

	logic [KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] val_mem [CAPACITY];

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         j_q;
	logic [CW-1:0]         n_q;
	logic                  hit_q;
	logic [1:0]            stg_status_q;
	logic [CW-1:0]         stg_pos_q;
	logic [VALUE_BITS-1:0] stg_val_q;
	logic                  rsp_valid_q;
	skt_pkg::skt_rsp_t     rsp_q;

	logic [KEY_BITS+31:0]   key_ext;
	logic [VALUE_BITS+31:0] val_ext;
	logic [KEY_BITS-1:0]    flip;
	logic [CW-1:0]          rd_addr;
	logic [CW-1:0]          wr_addr;
	logic [CW:0]            j_plus;
	logic [CW+3:0]          pos_ext;
	logic [CW+4:0]          cnt_ext;
	logic [VALUE_BITS+31:0] fv_ext;

	// Packs the staged fields into a result item at the output widths.
	function automatic skt_pkg::skt_rsp_t rsp_nxt(
		input logic [1:0]            st,
		input logic [CW+3:0]         pe,
		input logic [VALUE_BITS+31:0] fe,
		input logic [CW+4:0]         ce
	);
		skt_pkg::skt_rsp_t r;
		r.status      = st;
		r.position    = pe[3:0];
		r.found_value = fe[31:0];
		r.entry_count = ce[4:0];
		return r;
	endfunction

	// Fit the request fields to the stored widths.
	assign key_ext = {{KEY_BITS{1'b0}}, req.key};
	assign val_ext = {{VALUE_BITS{1'b0}}, req.value};

	// Flipping the top bit makes unsigned order match two's complement order.
	assign flip = key_signed ? KEY_TOP : '0;

	assign j_plus = {1'b0, j_q} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		case (cmd.rd_addr_sel)
			skt_pkg::ADDR_BELOW_J: rd_addr = j_q - CW'(1);
			skt_pkg::ADDR_ABOVE_J: rd_addr = j_plus[CW-1:0];
			default:               rd_addr = i_q;
		endcase
	end

	assign wr_addr = cmd.wr_new ? i_q : j_q;

	// Status for the controller.
	always_comb begin
		stat          = '0;
		stat.full     = (n_q >= CAP_CW);
		stat.i_at_n   = (i_q >= n_q);
		stat.less     = ((rd_key_q ^ flip) < (key_q ^ flip));
		stat.hit      = hit_q;
		stat.j_eq_i   = (j_q == i_q);
		stat.j_last   = (j_plus >= {1'b0, n_q});
		stat.out_busy = rsp_valid_q && !rsp_ready;
	end

	// Entry memories: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_addr[AW-1:0]] <= cmd.wr_new ? key_q : rd_key_q;
			val_mem[wr_addr[AW-1:0]] <= cmd.wr_new ? val_q : rd_val_q;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr[AW-1:0]];
			rd_val_q <= val_mem[rd_addr[AW-1:0]];
		end
	end

	assign pos_ext = {4'd0, stg_pos_q};
	assign cnt_ext = {5'd0, n_q};
	assign fv_ext  = {32'd0, stg_val_q};

	// Operands of the item in progress and the staged result.
	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			key_q <= key_ext[KEY_BITS-1:0];
			val_q <= val_ext[VALUE_BITS-1:0];
		end
		if (cmd.stage_en) begin
			stg_status_q <= cmd.stage_status;
			stg_pos_q    <= cmd.stage_pos ? i_q : '0;
			stg_val_q    <= cmd.stage_val ? rd_val_q : '0;
		end
		if (cmd.res_load) begin
			rsp_q <= rsp_nxt(stg_status_q, pos_ext, fv_ext, cnt_ext);
		end
	end

	// Search position, shift index, entry count and match flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.j_load_n) begin
				j_q <= n_q;
			end else if (cmd.j_load_i) begin
				j_q <= i_q;
			end else if (cmd.j_dec) begin
				j_q <= j_q - CW'(1);
			end else if (cmd.j_inc) begin
				j_q <= j_plus[CW-1:0];
			end
			if (cmd.clr_count) begin
				n_q <= '0;
			end else if (cmd.n_inc) begin
				n_q <= n_q + CW'(1);
			end else if (cmd.n_dec) begin
				n_q <= n_q - CW'(1);
			end
			if (cmd.hit_clr) begin
				hit_q <= 1'b0;
			end else if (cmd.hit_cap) begin
				hit_q <= (rd_key_q == key_q);
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/sorted_key_table.sv
// Ordered key/value table of up to CAPACITY entries, kept in ascending key order in
// two entry memories. Each request item inserts, looks up, deletes or clears, and gives
// exactly one result item. The next item is taken only after the current one has handed
// its result to the output register. A clear, or an insert into a full table, is decided
// at once, with no search. Every other item first runs a linear search that reads the
// entries in order: the keys below the request key plus the first one that is not, or
// every entry when all keys are below it. Each scan step is a registered read and then
// the compare. An insert or a delete that changes the table then moves the larger
// entries, up one place on insert or down one place on delete, and each move step is a
// read and then the write. A finished item also waits for as long as the previous result
// is still held by the receiver. Reset empties the table at once; there is no clearing
// pass. The key_signed register selects two's complement or unsigned key order and
// should only be changed while the table is empty or idle with keys already ordered
// for the new setting.
module sorted_key_table #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  skt_pkg::skt_req_t                 req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output skt_pkg::skt_rsp_t                 rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [skt_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	skt_pkg::skt_cmd_t  cmd;
	skt_pkg::skt_stat_t stat;
	logic               key_signed_q;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_signed_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == skt_pkg::REG_KEY_SIGNED) begin
			key_signed_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == skt_pkg::REG_KEY_SIGNED) ? {31'd0, key_signed_q} : 32'd0;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_mode  (req.mode),
		.stat      (stat),
		.cmd       (cmd)
	);

	skt_datapath #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.key_signed (key_signed_q),
		.cmd        (cmd),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// File: hw/rtl/skt_checker.sv
module skt_checker #(
	parameter int CAPACITY = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input skt_pkg::skt_rsp_t rsp
);

	// A result item that is not taken stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// A full table rejects an insert with no position or value.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == skt_pkg::ST_FULL |->
		rsp.position == 4'd0 && rsp.found_value == 32'd0)
		else $error("full result carries position or value");

	// A missed key reports neither position nor value.
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == skt_pkg::ST_MISS |->
		rsp.position == 4'd0 && rsp.found_value == 32'd0)
		else $error("miss result carries position or value");

	// A duplicate never returns a payload, and the count never passes capacity.
	a_dup_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
		(rsp.status != skt_pkg::ST_DUP || rsp.found_value == 32'd0) &&
		(32'(rsp.entry_count) <= CAPACITY))
		else $error("duplicate payload or entry count beyond capacity");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (.*);

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE       = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 200;
	localparam int POOL_SIZE    = 20;
	localparam int REPORT_LIMIT = 10;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_KEY_SIGNED = APB_ADDR_BITS'(4 * REG_KEY_SIGNED);

	// One row of the directed stimulus: key order, request and an optional typed result.
	typedef struct {
		bit       sgn;
		skt_req_t item;
		bit       typed;
		skt_rsp_t want;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	skt_req_t                 req = '0;
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	skt_rsp_t                 rsp;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	// Shadow copy of the table contents and the key order setting.
	logic [31:0] shadow_keys [CAPACITY];
	logic [31:0] shadow_vals [CAPACITY];
	int          shadow_count = 0;
	bit          shadow_signed = 1'b0;

	skt_rsp_t    pending_results [$];
	dir_row_t    dir_rows [$];
	logic [31:0] key_pool [POOL_SIZE];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          gaps_on = 1'b1;
	bit          hold_request = 1'b0;
	int          hold_left = 0;

	sorted_key_table #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(32),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// Run length guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Maps a key so that unsigned comparison follows the selected key order.
	function automatic logic [31:0] order_key(logic [31:0] k);
		return shadow_signed ? (k ^ 32'h8000_0000) : k;
	endfunction

	// Applies one request to the shadow table and returns the result it must produce.
	function automatic skt_rsp_t apply_table_op(skt_req_t item);
		skt_rsp_t r;
		int       pos;
		bit       hit;
		r = '0;
		if (item.mode == MODE_CLEAR) begin
			shadow_count = 0;
			r.status = ST_OK;
			return r;
		end
		pos = 0;
		while (pos < shadow_count && order_key(shadow_keys[pos]) < order_key(item.key))
			pos++;
		hit = (pos < shadow_count) && (shadow_keys[pos] == item.key);
		if (item.mode == MODE_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else if (hit) begin
				r.status = ST_DUP;
				r.position = 4'(pos);
			end else begin
				for (int i = shadow_count; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i - 1];
					shadow_vals[i] = shadow_vals[i - 1];
				end
				shadow_keys[pos] = item.key;
				shadow_vals[pos] = item.value;
				shadow_count++;
				r.status = ST_OK;
				r.position = 4'(pos);
			end
		end else if (!hit) begin
			r.status = ST_MISS;
		end else begin
			r.status = ST_OK;
			r.position = 4'(pos);
			r.found_value = shadow_vals[pos];
			if (item.mode == MODE_DELETE) begin
				for (int i = pos; i + 1 < shadow_count; i++) begin
					shadow_keys[i] = shadow_keys[i + 1];
					shadow_vals[i] = shadow_vals[i + 1];
				end
				shadow_count--;
			end
		end
		r.entry_count = 5'(shadow_count);
		return r;
	endfunction

	// Offers one item, with random gaps before it, and records its result on acceptance.
	task automatic send_item(skt_req_t item, bit typed, skt_rsp_t want);
		skt_rsp_t predicted;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = apply_table_op(item);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Waits until every result is back and the block has settled.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write on the configuration port: a setup phase and then an access phase.
	task automatic write_key_order(bit sgn);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_KEY_SIGNED;
		pwdata <= {31'd0, sgn};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		shadow_signed = sgn;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic skt_req_t make_req(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
		skt_req_t r;
		r.mode = mode;
		r.key = key;
		r.value = value;
		return r;
	endfunction

	function automatic skt_rsp_t make_rsp(logic [1:0] status, logic [3:0] position,
			logic [31:0] found_value, logic [4:0] entry_count);
		skt_rsp_t r;
		r.status = status;
		r.position = position;
		r.found_value = found_value;
		r.entry_count = entry_count;
		return r;
	endfunction

	task automatic add_row(bit sgn, skt_req_t item, bit typed, skt_rsp_t want);
		dir_row_t row;
		row.sgn = sgn;
		row.item = item;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Directed rows: misses on an empty table, extremes, duplicate, fill to full, signed order.
	task automatic load_directed();
		add_row(0, make_req(MODE_LOOKUP, 32'd5, 32'd0), 1, make_rsp(ST_MISS, 4'd0, 32'd0, 5'd0));
		add_row(0, make_req(MODE_DELETE, 32'd5, 32'd0), 1, make_rsp(ST_MISS, 4'd0, 32'd0, 5'd0));
		add_row(0, make_req(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF), 1,
			make_rsp(ST_OK, 4'd0, 32'd0, 5'd1));
		add_row(0, make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000), 1,
			make_rsp(ST_OK, 4'd1, 32'd0, 5'd2));
		add_row(0, make_req(MODE_INSERT, 32'h8000_0000, 32'h1234_5678), 0, '0);
		add_row(0, make_req(MODE_INSERT, 32'h0000_0000, 32'd5), 1,
			make_rsp(ST_DUP, 4'd0, 32'd0, 5'd3));
		add_row(0, make_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0);
		add_row(0, make_req(MODE_DELETE, 32'h0000_0000, 32'd0), 1,
			make_rsp(ST_OK, 4'd0, 32'hFFFF_FFFF, 5'd2));
		add_row(0, make_req(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
			make_rsp(ST_OK, 4'd0, 32'd0, 5'd0));
		// Descending keys so that every insert moves all stored entries up.
		for (int i = 0; i < CAPACITY; i++)
			add_row(0, make_req(MODE_INSERT, 32'hF000_0000 - 32'(i) * 32'h0F00_0001,
				~(32'h0101_0101 * 32'(i))), 0, '0);
		add_row(0, make_req(MODE_INSERT, 32'd0, 32'd0), 1,
			make_rsp(ST_FULL, 4'd0, 32'd0, 5'd16));
		add_row(0, make_req(MODE_CLEAR, 32'd0, 32'd0), 1, make_rsp(ST_OK, 4'd0, 32'd0, 5'd0));
		add_row(1, make_req(MODE_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5), 1,
			make_rsp(ST_OK, 4'd0, 32'd0, 5'd1));
		add_row(1, make_req(MODE_INSERT, 32'h8000_0000, 32'h5A5A_5A5A), 1,
			make_rsp(ST_OK, 4'd0, 32'd0, 5'd2));
		add_row(1, make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h0F0F_0F0F), 0, '0);
	endtask

	// Fresh key pool for a random phase: the extremes plus random keys.
	task automatic refill_pool();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
	endtask

	// Random request: mostly pool keys so that hits, duplicates and a full table happen.
	function automatic skt_req_t random_req();
		skt_req_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 48)
			r.mode = MODE_INSERT;
		else if (pick < 74)
			r.mode = MODE_LOOKUP;
		else if (pick < 98)
			r.mode = MODE_DELETE;
		else
			r.mode = MODE_CLEAR;
		if ($urandom_range(7) == 0)
			r.key = $urandom;
		else
			r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
		r.value = $urandom;
		return r;
	endfunction

	// Empties the table, then changes the key order while the block is idle.
	task automatic switch_key_order(bit sgn);
		send_item(make_req(MODE_CLEAR, $urandom, $urandom), 0, '0);
		wait_drained();
		write_key_order(sgn);
	endtask

	// Receiver ready: random idling plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request <= 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= !(gaps_on && $urandom_range(99) < 6);
		end
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected result item: status %0d position %0d value %h count %0d",
						rsp.status, rsp.position, rsp.found_value, rsp.entry_count);
			end else begin
				if (rsp !== pending_results[0]) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Mismatch: expected st %0d pos %0d val %h cnt %0d, got st %0d pos %0d val %h cnt %0d",
							pending_results[0].status, pending_results[0].position,
							pending_results[0].found_value, pending_results[0].entry_count,
							rsp.status, rsp.position, rsp.found_value, rsp.entry_count);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, with a register write wherever the key order changes.
		load_directed();
		foreach (dir_rows[n]) begin
			if (dir_rows[n].sgn != shadow_signed) begin
				wait_drained();
				write_key_order(dir_rows[n].sgn);
			end
			send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
		end

		// Random phases, alternating key order; one without idling, one with a long hold-off.
		for (int phase = 0; phase < 4; phase++) begin
			switch_key_order(phase[0]);
			refill_pool();
			gaps_on = (phase != 1);
			if (phase == 2)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS) send_item(random_req(), 0, '0);
		end
		gaps_on = 1'b1;

		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
